FILE: rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Shared constants, S-box tables and GF(2^8) helpers for the cipher pipeline.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int KEY_W      = 64;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    localparam logic MODE_ENCRYPT = 1'b0;

    localparam logic [7:0] GF_POLY = 8'h1b;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
    endfunction

    // Round constant for round r (1..10).
    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] c;
        c = 8'h01;
        for (int i = 1; i < NUM_ROUNDS; i++) begin
            if (i < int'(r)) c = xtime(c);
        end
        return c;
    endfunction

    // State bytes are indexed 0..15 in column-major order; byte 0 sits in bits 127:120.
    function automatic logic [7:0] sbyte(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    // Next round key from the previous one.
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [3:0] r);
        logic [31:0] w [4];
        logic [31:0] t;
        for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
        t = {sbox(w[3][23:16]) ^ rcon(r), sbox(w[3][15:8]), sbox(w[3][7:0]),
             sbox(w[3][31:24])};
        w[0] = w[0] ^ t;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
        return {w[0], w[1], w[2], w[3]};
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) t[c*4+r] = sbox(sbyte(s, ((c + r) % 4) * 4 + r));
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
            if (!last) begin
                t[c*4]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                t[c*4+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                t[c*4+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                t[c*4+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
        return o;
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] acc, p;
        acc = 8'h00;
        p = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) acc = acc ^ p;
            p = xtime(p);
        end
        return acc;
    endfunction

    // Inverse MixColumns on a whole state.
    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            a0 = sbyte(s, c*4); a1 = sbyte(s, c*4+1);
            a2 = sbyte(s, c*4+2); a3 = sbyte(s, c*4+3);
            o[127-8*(c*4) -: 8]   = gmul(a0, 4'he) ^ gmul(a1, 4'hb) ^ gmul(a2, 4'hd) ^ gmul(a3, 4'h9);
            o[127-8*(c*4+1) -: 8] = gmul(a0, 4'h9) ^ gmul(a1, 4'he) ^ gmul(a2, 4'hb) ^ gmul(a3, 4'hd);
            o[127-8*(c*4+2) -: 8] = gmul(a0, 4'hd) ^ gmul(a1, 4'h9) ^ gmul(a2, 4'he) ^ gmul(a3, 4'hb);
            o[127-8*(c*4+3) -: 8] = gmul(a0, 4'hb) ^ gmul(a1, 4'hd) ^ gmul(a2, 4'h9) ^ gmul(a3, 4'he);
        end
        return o;
    endfunction

    // Inverse ShiftRows and inverse SubBytes.
    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127-8*(((c + r) % 4) * 4 + r) -: 8] = inv_sbox(sbyte(s, c*4 + r));
            end
        end
        return o;
    endfunction

endpackage

FILE: rtl/aes128_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Fully unrolled round pipeline for encryption and decryption.
// ----------------------------------------------------------------------------
// Usage:
//   The key is written through the cfg channel (index 0 = key bytes 0..7,
//   index 1 = key bytes 8..15) while no block is in flight. The round keys
//   are expanded through a register chain, one round key per cycle, so
//   s_axis_tready stays low after each key write and after reset until the
//   chain holds the new key; a block offered meanwhile simply waits.
//   One input beat carries a 128-bit block and tuser holds the mode bit
//   (0 encrypt, 1 decrypt). The result beat leaves on the m_ channel.
//   The pipeline has 11 register stages: the initial AddRoundKey and one
//   stage per round, each holding SubBytes, ShiftRows, MixColumns (left out
//   in the last round) and AddRoundKey, or their inverses when decrypting.
//   One block is accepted every cycle unless a stall or key settle holds input.
//   When m_axis_tready is low with the output stage full, the whole pipeline
//   holds and s_axis_tready goes low, so no beat is lost.
//   Reset clears all valid bits and both key registers.
// ----------------------------------------------------------------------------
module aes128_block_cipher
    import aes_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: block_high [63:0], block_low [127:64]
    input  logic [127:0]         s_axis_tdata,
    // tuser: mode [0]
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: result_high [63:0], result_low [127:64]
    output logic [127:0]         m_axis_tdata
);

    localparam int NST = NUM_ROUNDS + 1;
    localparam logic [3:0] SETTLE_CYCLES = 4'(NST);

    logic [KEY_W-1:0] key_high_reg, key_low_reg;
    logic [127:0]     rk_reg [NST];
    logic [127:0]     rk_next [NST];
    logic [127:0]     st_reg [NST];
    logic [NST-1:0]   vld_reg;
    logic [NST-2:0]   mode_reg;
    logic [3:0]       settle_reg;
    logic             adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // The key schedule is a chain of registers, one round key per cycle.
    always_comb begin
        rk_next[0] = {key_high_reg, key_low_reg};
        for (int r = 1; r < NST; r++) rk_next[r] = key_step(rk_reg[r-1], 4'(r));
    end

    always_ff @(posedge aclk) begin
        for (int r = 0; r < NST; r++) rk_reg[r] <= rk_next[r];
    end

    // Input waits until the whole round key chain holds the current key.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_CYCLES;
        end else if (cfg_valid && cfg_ready) begin
            settle_reg <= SETTLE_CYCLES;
        end else if (settle_reg != '0) begin
            settle_reg <= settle_reg - 4'd1;
        end
    end

    // The pipeline advances when the output stage is empty or being taken.
    assign adv           = !vld_reg[NST-1] || m_axis_tready;
    assign s_axis_tready = adv && (settle_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid && s_axis_tready};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mode_reg <= {mode_reg[NST-3:0], s_axis_tuser};
            // Decryption uses the inverse cipher order: InvShiftRows/InvSubBytes,
            // AddRoundKey, InvMixColumns; the first key is the last round key.
            if (s_axis_tuser == MODE_ENCRYPT) begin
                st_reg[0] <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ rk_reg[0];
            end else begin
                st_reg[0] <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ rk_reg[NUM_ROUNDS];
            end
            for (int r = 1; r < NST; r++) begin
                if (mode_reg[r-1] == MODE_ENCRYPT) begin
                    st_reg[r] <= enc_round(st_reg[r-1], r == NUM_ROUNDS) ^ rk_reg[r];
                end else if (r == NUM_ROUNDS) begin
                    st_reg[r] <= inv_sub_shift(st_reg[r-1]) ^ rk_reg[0];
                end else begin
                    st_reg[r] <= inv_mix(inv_sub_shift(st_reg[r-1]) ^ rk_reg[NUM_ROUNDS-r]);
                end
            end
        end
    end

    assign m_axis_tvalid = vld_reg[NST-1];
    assign m_axis_tdata  = {st_reg[NST-1][63:0], st_reg[NST-1][127:64]};

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid && settle_reg == '0 |-> s_axis_tready)
        else $error("pipeline refused input with an empty output stage");
    a_valid_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted beat not tracked");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Streams blocks in both directions under several keys. A scoreboard
// computes each expected result from its own AES-128 model, keyed by the
// accepted configuration writes. It compares every result beat in order.
// ----------------------------------------------------------------------------
module testbench;
    import aes_pkg::*;

    typedef struct packed {
        logic [63:0] res_high;
        logic [63:0] res_low;
    } cipher_out_t;

    class cipher_scoreboard;
        logic [7:0]  fwd_box [256];
        logic [7:0]  inv_box [256];
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        cipher_out_t pending_q[$];
        int          mismatches;
        int          checked;

        function new();
            logic [7:0] inv, b;
            key_hi = '0;
            key_lo = '0;
            mismatches = 0;
            checked = 0;
            // The S-box is the field inverse followed by the affine map.
            for (int x = 0; x < 256; x++) begin
                inv = 8'h00;
                for (int y = 1; y < 256; y++) begin
                    if (gf_mult(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
                end
                b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                    ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
                fwd_box[x] = b;
                inv_box[b] = 8'(x);
            end
        endfunction

        function logic [7:0] gf_mult(logic [7:0] a, logic [7:0] b);
            logic [7:0] acc;
            acc = 8'h00;
            for (int i = 0; i < 8; i++) begin
                if (b[i]) acc ^= a;
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            end
            return acc;
        endfunction

        function void set_key(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
            if (idx == REG_KEY_HIGH) key_hi = val;
            else if (idx == REG_KEY_LOW) key_lo = val;
        endfunction

        function void mix_state(ref logic [7:0] s [16], input logic [7:0] m [4]);
            logic [7:0] col [4];
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) col[r] = s[c*4+r];
                for (int r = 0; r < 4; r++) begin
                    s[c*4+r] = gf_mult(col[0], m[(4-r)&3]) ^ gf_mult(col[1], m[(5-r)&3])
                             ^ gf_mult(col[2], m[(6-r)&3]) ^ gf_mult(col[3], m[(7-r)&3]);
                end
            end
        endfunction

        function cipher_out_t run_cipher(logic decrypt, logic [63:0] hi, logic [63:0] lo);
            logic [7:0] rk [176];
            logic [7:0] s [16];
            logic [7:0] t [16];
            logic [7:0] w [4];
            logic [7:0] rc, f;
            logic [7:0] fwd_m [4];
            logic [7:0] inv_m [4];
            cipher_out_t o;
            fwd_m = '{8'h02, 8'h03, 8'h01, 8'h01};
            inv_m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
            for (int i = 0; i < 8; i++) begin
                rk[i] = key_hi[63-8*i -: 8];
                rk[8+i] = key_lo[63-8*i -: 8];
                s[i] = hi[63-8*i -: 8];
                s[8+i] = lo[63-8*i -: 8];
            end
            rc = 8'h01;
            for (int i = 4; i < 44; i++) begin
                for (int j = 0; j < 4; j++) w[j] = rk[(i-1)*4+j];
                if ((i % 4) == 0) begin
                    f = w[0];
                    w[0] = fwd_box[w[1]] ^ rc;
                    w[1] = fwd_box[w[2]];
                    w[2] = fwd_box[w[3]];
                    w[3] = fwd_box[f];
                    rc = gf_mult(rc, 8'h02);
                end
                for (int j = 0; j < 4; j++) rk[i*4+j] = rk[(i-4)*4+j] ^ w[j];
            end
            if (!decrypt) begin
                for (int i = 0; i < 16; i++) s[i] ^= rk[i];
                for (int rnd = 1; rnd <= NUM_ROUNDS; rnd++) begin
                    for (int c = 0; c < 4; c++)
                        for (int r = 0; r < 4; r++)
                            t[c*4+r] = fwd_box[s[((c+r)%4)*4+r]];
                    s = t;
                    if (rnd != NUM_ROUNDS) mix_state(s, fwd_m);
                    for (int i = 0; i < 16; i++) s[i] ^= rk[rnd*16+i];
                end
            end else begin
                for (int i = 0; i < 16; i++) s[i] ^= rk[NUM_ROUNDS*16+i];
                for (int rnd = NUM_ROUNDS; rnd > 0; rnd--) begin
                    for (int c = 0; c < 4; c++)
                        for (int r = 0; r < 4; r++)
                            t[((c+r)%4)*4+r] = inv_box[s[c*4+r]];
                    s = t;
                    for (int i = 0; i < 16; i++) s[i] ^= rk[(rnd-1)*16+i];
                    if (rnd != 1) mix_state(s, inv_m);
                end
            end
            for (int i = 0; i < 8; i++) begin
                o.res_high[63-8*i -: 8] = s[i];
                o.res_low[63-8*i -: 8] = s[8+i];
            end
            return o;
        endfunction

        function void note_block(logic mode, logic [63:0] hi, logic [63:0] lo);
            pending_q.push_back(run_cipher(mode != MODE_ENCRYPT, hi, lo));
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH %s: got %h, want %h (beat %0d)", what, got, want, checked);
            mismatches++;
        endtask

        task check_result(logic [63:0] hi, logic [63:0] lo);
            cipher_out_t want;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected beat", hi, 64'h0);
            end else begin
                want = pending_q.pop_front();
                if (hi !== want.res_high) report_mismatch("result_high", hi, want.res_high);
                if (lo !== want.res_low) report_mismatch("result_low", lo, want.res_low);
            end
            checked++;
        endtask
    endclass

    localparam int PIPE_LATENCY = 11;
    localparam int KEY_SETTLE   = 20;
    localparam int STALL_LIMIT  = 5000;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KEY_W-1:0]     cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [127:0]         s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [127:0]         m_axis_tdata;

    cipher_scoreboard sb;
    int  idle_cycles;
    int  enc_blocks;
    int  dec_blocks;
    int  key_phases;
    int  sink_hold;
    bit  no_gaps;

    aes128_block_cipher DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function int pick_gap();
        int roll;
        if (no_gaps) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Monitor: scoreboard updates on every accepted beat.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.set_key(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_block(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[127:64]);
                if (s_axis_tuser == MODE_ENCRYPT) enc_blocks++;
                else dec_blocks++;
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[63:0], m_axis_tdata[127:64]);
        end
    end

    // Result sink with random back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            sink_hold <= pick_gap();
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task send_block(logic mode, logic [63:0] hi, logic [63:0] lo);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {lo, hi};
        s_axis_tuser <= mode;
        @(negedge aclk);
        while (!s_axis_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // The key may only change with the pipeline empty; the block then needs
    // time to expand the new round keys.
    task load_key(logic [63:0] hi, logic [63:0] lo);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
        write_reg(REG_KEY_HIGH, hi);
        write_reg(REG_KEY_LOW, lo);
        cfg_valid <= 1'b0;
        repeat (KEY_SETTLE) @(posedge aclk);
        key_phases++;
    endtask

    function logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task random_blocks(int count);
        logic [63:0] hi, lo;
        int roll;
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 9);
            hi = rand64();
            lo = rand64();
            if (roll == 0) hi = '0;
            else if (roll == 1) lo = '1;
            send_block($urandom_range(0, 1), hi, lo);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        int limit;
        sb = new();
        idle_cycles = 0;
        enc_blocks = 0;
        dec_blocks = 0;
        key_phases = 0;
        no_gaps = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_KEY_HIGH;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_ENCRYPT;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (KEY_SETTLE) @(posedge aclk);

        // Directed: reset key, standard test key, all-ones key, then high zeros/low ones.
        send_block(1'b0, '0, '0);
        send_block(1'b1, '0, '0);
        send_block(1'b0, '1, '1);
        send_block(1'b1, '1, '1);
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(1'b0, '0, '1);
        send_block(1'b1, '1, '0);
        send_block(1'b0, 64'h8000000000000000, 64'h0000000000000001);
        load_key('1, '1);
        send_block(1'b0, '0, '0);
        send_block(1'b1, '0, '0);
        send_block(1'b0, '1, '1);
        send_block(1'b1, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        load_key('0, '1);
        send_block(1'b0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        send_block(1'b1, '1, '1);

        // Random: a fresh key per phase, the last one back to all zeros.
        for (int p = 0; p < 6; p++) begin
            load_key(rand64(), rand64());
            random_blocks(250);
        end
        load_key('0, '0);
        random_blocks(30);

        s_axis_tvalid <= 1'b0;
        limit = 0;
        while (sb.pending_q.size() != 0 && limit < STALL_LIMIT) begin
            @(posedge aclk);
            limit++;
        end
        repeat (PIPE_LATENCY * 3) @(posedge aclk);

        $display("Covered %0d encrypt and %0d decrypt blocks over %0d key settings.",
                 enc_blocks, dec_blocks, key_phases);
        $display("Checked %0d result beats, %0d still pending.",
                 sb.checked, sb.pending_q.size());
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
